### src/integer_field_formatter_macros.svh
// Assertion macros for the integer field formatter checker
`ifndef INTEGER_FIELD_FORMATTER_MACROS_SVH
`define INTEGER_FIELD_FORMATTER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define IFF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer_field_formatter: check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define IFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer_field_formatter: check failed");

`endif

### src/iff_pkg.sv
// Types, constants and helpers for the integer field formatter
`default_nettype none

package iff_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_NORM,
    S_SETUP,
    S_EMIT
  } iff_state_t;

  // input request layout
  localparam int IN_TDATA_W  = 48;
  localparam int VAL_FIELD_W = 32;
  localparam int HW_BIT      = 32;
  localparam int W_LSB       = 33;
  localparam int HP_BIT      = 39;
  localparam int P_LSB       = 40;
  localparam int LEN_FIELD_W = 6;

  localparam int OUT_TDATA_W = 8;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_HEX_LO = 8'h57;  // 'a' less ten

  localparam logic MODE_DEC = 1'b0;
  localparam logic MODE_HEX = 1'b1;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'h0, d};
    end else begin
      return CHAR_HEX_LO + {4'h0, d};
    end
  endfunction

endpackage

`default_nettype wire

### src/integer_field_formatter.sv
// Integer field formatter: %d/%x, width, precision; one char per cycle unless stalled
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | tuser mode; tdata value, widths, precisions
//  out_    | out | out_tvalid / out_tready| tdata out_char; tlast last
//
// Decimal: a load, then double-dabble conversion; hex skips the conversion.
// Then leading zero digits are trimmed (at least one digit is kept), a setup step runs,
// and the characters are sent while the output register is free.
// One request at a time: in_tready is high only when idle; the last character
// may still sit in the output register while the next request is taken.
// rst_n is synchronous, active low; out_tready low holds the current character.
`default_nettype none

module integer_field_formatter
  import iff_pkg::*;
#(
  parameter int MAX_FIELD  = 63,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [31:0] value, [32] has_width, [38:33] width, [39] has_precision,
  // [45:40] precision, [47:46] unused
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] mode
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [7:0] out_char
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  localparam int NDIG = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int DW   = NDIG * 4;
  localparam int ND_W = $clog2(NDIG + 1);
  localparam int BC_W = $clog2(VALUE_BITS + 1);
  localparam int CW   = ($clog2(MAX_FIELD + 2) > 7) ? $clog2(MAX_FIELD + 2) : 7;
  localparam logic [CW-1:0] MAXW = CW'(MAX_FIELD);
  localparam logic [CW-1:0] MAXP = CW'(MAX_FIELD - 1);

  iff_state_t state_r, state_nxt;

  logic                  hex_r, hex_nxt;
  logic                  neg_r, neg_nxt;
  logic                  zero_r, zero_nxt;
  logic                  hasw_r, hasw_nxt;
  logic                  hasp_r, hasp_nxt;
  logic [CW-1:0]         width_r, width_nxt;
  logic [CW-1:0]         prec_r, prec_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [DW-1:0]         dig_r, dig_nxt;
  logic [BC_W-1:0]       bcnt_r, bcnt_nxt;
  logic [ND_W-1:0]       ndig_r, ndig_nxt;
  logic [CW-1:0]         sp_r, sp_nxt;
  logic [CW-1:0]         zr_r, zr_nxt;
  logic                  minus_r, minus_nxt;
  logic                  blank_r, blank_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0] in_value;
  logic [CW-1:0]         in_width;
  logic [CW-1:0]         in_prec;
  logic                  in_neg;
  logic [DW-1:0]         dig_adj;
  logic [CW-1:0]         ndig_c;
  logic                  use_prec;
  logic                  special;
  logic [CW-1:0]         zeros_c;
  logic [CW-1:0]         total_c;
  logic [CW-1:0]         spaces_c;
  logic [CW-1:0]         dcount_c;
  logic                  out_free;

  assign in_value = in_tdata[VALUE_BITS-1:0];
  assign in_width = CW'(in_tdata[W_LSB +: LEN_FIELD_W]);
  assign in_prec  = CW'(in_tdata[P_LSB +: LEN_FIELD_W]);
  assign in_neg   = (in_tuser == MODE_DEC) && in_value[VALUE_BITS-1];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      dig_adj[i*4 +: 4] = (dig_r[i*4 +: 4] >= 4'd5) ? dig_r[i*4 +: 4] + 4'd3
                                                     : dig_r[i*4 +: 4];
    end
  end

  assign ndig_c   = CW'(ndig_r);
  assign use_prec = hasp_r && (prec_r > ndig_c);
  assign special  = zero_r && hasp_r && (prec_r == '0);
  assign zeros_c  = use_prec ? prec_r - ndig_c : '0;
  assign total_c  = (use_prec ? prec_r : ndig_c) + CW'(neg_r);
  assign spaces_c = (hasw_r && (width_r > total_c)) ? width_r - total_c : '0;
  assign dcount_c = special ? ((hasw_r && (width_r != '0)) ? CW'(1) : '0) : ndig_c;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    hex_nxt       = hex_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    hasw_nxt      = hasw_r;
    hasp_nxt      = hasp_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    mag_nxt       = mag_r;
    dig_nxt       = dig_r;
    bcnt_nxt      = bcnt_r;
    ndig_nxt      = ndig_r;
    sp_nxt        = sp_r;
    zr_nxt        = zr_r;
    minus_nxt     = minus_r;
    blank_nxt     = blank_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          hex_nxt   = (in_tuser == MODE_HEX);
          neg_nxt   = in_neg;
          zero_nxt  = (in_value == '0);
          hasw_nxt  = in_tdata[HW_BIT];
          hasp_nxt  = in_tdata[HP_BIT];
          width_nxt = (in_width > MAXW) ? MAXW : in_width;
          prec_nxt  = (in_prec > MAXP) ? MAXP : in_prec;
          mag_nxt   = in_neg ? (~in_value + 1'b1) : in_value;
          bcnt_nxt  = BC_W'(VALUE_BITS);
          ndig_nxt  = ND_W'(NDIG);
          if (in_tuser == MODE_HEX) begin
            dig_nxt   = DW'(in_value);
            state_nxt = S_NORM;
          end else begin
            dig_nxt   = '0;
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        dig_nxt  = {dig_adj[DW-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt  = mag_r << 1;
        bcnt_nxt = bcnt_r - 1'b1;
        if (bcnt_r == BC_W'(1)) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if ((dig_r[DW-1 -: 4] == 4'd0) && (ndig_r > ND_W'(1))) begin
          dig_nxt  = dig_r << 4;
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        sp_nxt    = spaces_c;
        zr_nxt    = zeros_c;
        minus_nxt = neg_r;
        blank_nxt = special;
        rem_nxt   = spaces_c + CW'(neg_r) + zeros_c + dcount_c;
        if ((spaces_c + CW'(neg_r) + zeros_c + dcount_c) == '0) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (rem_r == CW'(1));
          rem_nxt       = rem_r - 1'b1;
          priority if (sp_r != '0) begin
            out_char_nxt = CHAR_SPACE;
            sp_nxt       = sp_r - 1'b1;
          end else if (minus_r) begin
            out_char_nxt = CHAR_MINUS;
            minus_nxt    = 1'b0;
          end else if (zr_r != '0) begin
            out_char_nxt = CHAR_ZERO;
            zr_nxt       = zr_r - 1'b1;
          end else begin
            out_char_nxt = blank_r ? CHAR_SPACE : digit_char(dig_r[DW-1 -: 4]);
            dig_nxt      = dig_r << 4;
          end
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hex_r      <= hex_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    hasw_r     <= hasw_nxt;
    hasp_r     <= hasp_nxt;
    width_r    <= width_nxt;
    prec_r     <= prec_nxt;
    mag_r      <= mag_nxt;
    dig_r      <= dig_nxt;
    bcnt_r     <= bcnt_nxt;
    ndig_r     <= ndig_nxt;
    sp_r       <= sp_nxt;
    zr_r       <= zr_nxt;
    minus_r    <= minus_nxt;
    blank_r    <= blank_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### src/iff_checker.sv
// Port-level checks for the integer field formatter, bound to the top level
`default_nettype none

`include "integer_field_formatter_macros.svh"

module iff_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // stalled character holds
  `IFF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // one request at a time
  `IFF_ASSERT_NEXT(a_in_single, in_tvalid && in_tready, !in_tready)

  // a field runs without gaps
  `IFF_ASSERT_NEXT(a_run_gapless, out_tvalid && out_tready && !out_tlast, out_tvalid)

  // no new request mid-field
  `IFF_ASSERT_IMPL(a_no_overlap, out_tvalid && !out_tlast, !in_tready)

endmodule

bind integer_field_formatter iff_checker u_iff_checker (.*);

`default_nettype wire
